@@ sv/cleb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor buffer package
// Shared constants, key codes, read status codes and the result type.
// ----------------------------------------------------------------------------
package cleb_pkg;

  localparam int unsigned CLEB_BUF_DEPTH = 128;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned CNT_W          = 8;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] KEY_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] KEY_CTRL_P = 8'h10;
  localparam logic [CHAR_W-1:0] KEY_CTRL_U = 8'h15;
  localparam logic [CHAR_W-1:0] KEY_CTRL_H = 8'h08;
  localparam logic [CHAR_W-1:0] KEY_DEL    = 8'h7f;
  localparam logic [CHAR_W-1:0] KEY_CTRL_D = 8'h04;
  localparam logic [CHAR_W-1:0] KEY_CR     = 8'h0d;
  localparam logic [CHAR_W-1:0] KEY_LF     = 8'h0a;

  localparam logic [1:0] RS_DELIVERED = 2'd0;
  localparam logic [1:0] RS_NO_DATA   = 2'd1;
  localparam logic [1:0] RS_EOF       = 2'd2;

  typedef struct packed {
    logic              echo_valid;
    logic [CHAR_W-1:0] echo_char;
    logic [CNT_W-1:0]  erase_count;
    logic              dump_request;
    logic              line_committed;
    logic [1:0]        read_status;
    logic [CHAR_W-1:0] read_char;
  } cleb_res_t;

endpackage
`default_nettype wire

@@ sv/cleb_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor buffer channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface cleb_in_if import cleb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [CHAR_W-1:0] key_code;
  logic              read_first;

  modport source (output valid, output opcode, output key_code, output read_first,
                  input ready);
  modport sink   (input valid, input opcode, input key_code, input read_first,
                  output ready);
endinterface

interface cleb_out_if import cleb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              echo_valid;
  logic [CHAR_W-1:0] echo_char;
  logic [CNT_W-1:0]  erase_count;
  logic              dump_request;
  logic              line_committed;
  logic [1:0]        read_status;
  logic [CHAR_W-1:0] read_char;

  modport source (output valid, output echo_valid, output echo_char, output erase_count,
                  output dump_request, output line_committed, output read_status,
                  output read_char, input ready);
  modport sink   (input valid, input echo_valid, input echo_char, input erase_count,
                  input dump_request, input line_committed, input read_status,
                  input read_char, output ready);
endinterface
`default_nettype wire

@@ sv/cleb_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cleb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/console_line_editor_buffer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor buffer
// Canonical console line discipline over a circular character store.
// ----------------------------------------------------------------------------
// Keys edit the uncommitted tail of a BUF_DEPTH-entry character store; read
// items pop committed bytes one at a time. Every item returns exactly one
// result. A plain key, backspace, delete or control-P finishes in the cycle
// it is accepted; a read item makes one store read, and control-U walks back
// through the store one entry per cycle on its single read port, erasing up
// to BUF_DEPTH - 1 characters. A new item is taken once the block is idle
// and the output register is free or being emptied. The store needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module console_line_editor_buffer import cleb_pkg::*; #(
  parameter int unsigned BUF_DEPTH = CLEB_BUF_DEPTH
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cleb_in_if.sink   in_i,
  cleb_out_if.source out_o
);

  localparam int unsigned IDX_W  = $clog2(2 * BUF_DEPTH);
  localparam int unsigned ADDR_W = $clog2(BUF_DEPTH);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(2 * BUF_DEPTH - 1);
  localparam logic [IDX_W-1:0] DEPTH_I  = IDX_W'(BUF_DEPTH);
  localparam logic [IDX_W:0]   IDX_MOD  = (IDX_W + 1)'(2 * BUF_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KILL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
    return (a == IDX_LAST) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
    return (a == '0) ? IDX_LAST : a - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_sub(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] diff;
    if (a >= b) begin
      diff = {1'b0, a} - {1'b0, b};
    end else begin
      diff = {1'b0, a} + IDX_MOD - {1'b0, b};
    end
    return diff[IDX_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] s;
    s = (a >= DEPTH_I) ? a - DEPTH_I : a;
    return s[ADDR_W-1:0];
  endfunction

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  read_q, read_d;
  logic [IDX_W-1:0]  commit_q, commit_d;
  logic [IDX_W-1:0]  edit_q, edit_d;
  logic              first_q, first_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  cleb_res_t         res_q, res_d, res_new;

  logic              out_free;
  logic              in_ready;
  logic              accept;
  logic [CHAR_W-1:0] key_char;
  logic [IDX_W-1:0]  edit_inc;
  logic              we;
  logic [ADDR_W-1:0] raddr;
  logic [CHAR_W-1:0] rdata;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = (state_q == ST_IDLE) && out_free;
  assign accept   = in_i.valid && in_ready;
  assign key_char = (in_i.key_code == KEY_CR) ? KEY_LF : in_i.key_code;
  assign edit_inc = idx_inc(edit_q);

  always_comb begin
    state_d     = state_q;
    read_d      = read_q;
    commit_d    = commit_q;
    edit_d      = edit_q;
    first_d     = first_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    we          = 1'b0;
    res_new     = '0;
    res_new.read_status = RS_NO_DATA;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.opcode == OP_READ) begin
            first_d = in_i.read_first;
            state_d = ST_READ;
          end else begin
            unique case (in_i.key_code) inside
              KEY_CTRL_P: begin
                res_new.dump_request = 1'b1;
                res_d       = res_new;
                out_valid_d = 1'b1;
              end
              KEY_CTRL_U: begin
                cnt_d   = '0;
                state_d = ST_KILL;
              end
              KEY_CTRL_H, KEY_DEL: begin
                if (edit_q != commit_q) begin
                  edit_d = idx_dec(edit_q);
                  res_new.erase_count = CNT_W'(1);
                end
                res_d       = res_new;
                out_valid_d = 1'b1;
              end
              default: begin
                if (in_i.key_code != KEY_NUL && idx_sub(edit_q, read_q) < DEPTH_I) begin
                  we     = 1'b1;
                  edit_d = edit_inc;
                  res_new.echo_valid = 1'b1;
                  res_new.echo_char  = key_char;
                  if (key_char == KEY_LF || key_char == KEY_CTRL_D ||
                      idx_sub(edit_inc, read_q) == DEPTH_I) begin
                    commit_d = edit_inc;
                    res_new.line_committed = 1'b1;
                  end
                end
                res_d       = res_new;
                out_valid_d = 1'b1;
              end
            endcase
          end
        end
      end
      ST_KILL: begin
        if (edit_q != commit_q && rdata != KEY_LF) begin
          edit_d = idx_dec(edit_q);
          cnt_d  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
        end else if (out_free) begin
          res_new.erase_count = cnt_q;
          res_d       = res_new;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          if (read_q != commit_q) begin
            if (rdata == KEY_CTRL_D) begin
              res_new.read_status = RS_EOF;
              if (first_q) begin
                read_d = idx_inc(read_q);
              end
            end else begin
              res_new.read_status = RS_DELIVERED;
              res_new.read_char   = rdata;
              read_d = idx_inc(read_q);
            end
          end
          res_d       = res_new;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // kill reads the entry just below the next edit index, one step ahead
  assign raddr = (state_q == ST_READ || (accept && in_i.opcode == OP_READ)) ?
                 slot(read_q) : slot(idx_dec(edit_d));

  cleb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUF_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot(edit_q)),
    .wdata_i (key_char),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      read_q      <= '0;
      commit_q    <= '0;
      edit_q      <= '0;
      first_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      read_q      <= read_d;
      commit_q    <= commit_d;
      edit_q      <= edit_d;
      first_q     <= first_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.echo_valid     = res_q.echo_valid;
  assign out_o.echo_char      = res_q.echo_char;
  assign out_o.erase_count    = res_q.erase_count;
  assign out_o.dump_request   = res_q.dump_request;
  assign out_o.line_committed = res_q.line_committed;
  assign out_o.read_status    = res_q.read_status;
  assign out_o.read_char      = res_q.read_char;

endmodule
`default_nettype wire

@@ sv/cleb_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor buffer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cleb_chk import cleb_pkg::*; (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  cleb_out_if.source out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.echo_char) &&
      $stable(out_o.erase_count) && $stable(out_o.read_status) && $stable(out_o.read_char))
    else $error("result item changed while stalled");

  a_key_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.echo_valid || out_o.erase_count != '0 || out_o.dump_request ||
      out_o.line_committed) |-> out_o.read_status == RS_NO_DATA && out_o.read_char == '0)
    else $error("key item result carries read data");

  a_commit_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.line_committed |->
      out_o.echo_valid && out_o.erase_count == '0 && !out_o.dump_request)
    else $error("commit without a stored character");

  a_read_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.read_status != RS_DELIVERED |->
      out_o.read_char == '0 &&
      (out_o.read_status == RS_NO_DATA || out_o.read_status == RS_EOF))
    else $error("bad read status or stray read character");

endmodule

bind console_line_editor_buffer cleb_chk u_cleb_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .out_o  (out_o)
);
`default_nettype wire

@@ tb/sv/console_line_editor_buffer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Console line editor buffer testbench
// Feeds key and read items through the input channel and checks every result
// against a line-discipline predictor: a short directed run over the editing
// keys, commits and end-of-file reads, then random typing sessions and
// noise under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module console_line_editor_buffer_tb;
  import cleb_pkg::*;

  localparam int unsigned IDX_W      = $clog2(2 * CLEB_BUF_DEPTH);
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned STALL_MAX  = 3000;
  localparam int unsigned PHASE_ITEMS = 270;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic              opcode;
    logic [CHAR_W-1:0] key_code;
    logic              read_first;
  } tty_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cleb_in_if  in_if ();
  cleb_out_if out_if ();

  console_line_editor_buffer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  tty_item_t         pending_q [$];
  cleb_res_t         reply_q [$];

  logic [CHAR_W-1:0] line_mem [CLEB_BUF_DEPTH];
  idx_t              read_ptr = '0;
  idx_t              commit_ptr = '0;
  idx_t              edit_ptr = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned stall_cnt = 0;

  int unsigned n_err = 0;
  int unsigned n_keys = 0;
  int unsigned n_reads = 0;
  int unsigned n_commits = 0;
  int unsigned n_eof = 0;
  int unsigned n_drops = 0;
  int unsigned n_results = 0;
  int unsigned max_kill = 0;

  tty_item_t   nxt_item;
  cleb_res_t   want_res;
  cleb_res_t   got_res;
  cleb_res_t   new_res;

  function automatic logic [CHAR_W-1:0] mem_at(idx_t p);
    return line_mem[p[IDX_W-2:0]];
  endfunction

  function automatic cleb_res_t tty_predict(logic op, logic [CHAR_W-1:0] key, logic first);
    cleb_res_t         r;
    int unsigned       kill;
    idx_t              fill;
    logic [CHAR_W-1:0] ch;
    r = '0;
    r.read_status = RS_NO_DATA;
    kill = 0;
    if (op == OP_KEY) begin
      fill = edit_ptr - read_ptr;
      if (key == KEY_CTRL_P) begin
        r.dump_request = 1'b1;
      end else if (key == KEY_CTRL_U) begin
        while (edit_ptr != commit_ptr && mem_at(edit_ptr - idx_t'(1)) != KEY_LF) begin
          edit_ptr = edit_ptr - idx_t'(1);
          kill++;
        end
      end else if (key == KEY_CTRL_H || key == KEY_DEL) begin
        if (edit_ptr != commit_ptr) begin
          edit_ptr = edit_ptr - idx_t'(1);
          kill = 1;
        end
      end else if (key != KEY_NUL && int'(fill) < int'(CLEB_BUF_DEPTH)) begin
        ch = (key == KEY_CR) ? KEY_LF : key;
        r.echo_valid = 1'b1;
        r.echo_char = ch;
        line_mem[edit_ptr[IDX_W-2:0]] = ch;
        edit_ptr = edit_ptr + idx_t'(1);
        fill = edit_ptr - read_ptr;
        if (ch == KEY_LF || ch == KEY_CTRL_D || int'(fill) == int'(CLEB_BUF_DEPTH)) begin
          commit_ptr = edit_ptr;
          r.line_committed = 1'b1;
        end
      end
      r.erase_count = (kill > 255) ? 8'd255 : kill[CNT_W-1:0];
    end else if (read_ptr != commit_ptr) begin
      ch = mem_at(read_ptr);
      if (ch == KEY_CTRL_D) begin
        r.read_status = RS_EOF;
        if (first) read_ptr = read_ptr + idx_t'(1);
      end else begin
        r.read_status = RS_DELIVERED;
        r.read_char = ch;
        read_ptr = read_ptr + idx_t'(1);
      end
    end
    return r;
  endfunction

  function automatic void push_key(logic [CHAR_W-1:0] k);
    pending_q.push_back('{opcode: OP_KEY, key_code: k, read_first: 1'($urandom_range(1))});
  endfunction

  function automatic void push_read(logic first);
    pending_q.push_back('{opcode: OP_READ, key_code: CHAR_W'($urandom_range(255)),
                          read_first: first});
  endfunction

  function automatic logic [CHAR_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return KEY_CTRL_H;
    if (r < 6) return KEY_DEL;
    if (r < 8) return KEY_CTRL_U;
    if (r < 10) return KEY_CTRL_P;
    if (r < 11) return KEY_NUL;
    return CHAR_W'($urandom_range(255));
  endfunction

  // typing session: a line with edits, usually a terminator, then pops of it; or a short burst of random noise items
  function automatic int unsigned queue_session();
    int unsigned roll;
    int unsigned len;
    int unsigned pops;
    int unsigned n;
    roll = $urandom_range(99);
    n = 0;
    if (roll < 20) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        pending_q.push_back('{opcode: 1'($urandom_range(1)),
                              key_code: CHAR_W'($urandom_range(255)),
                              read_first: 1'($urandom_range(1))});
      end
      return n;
    end
    len = (roll < 27) ? $urandom_range(100, 140) : $urandom_range(0, 14);
    repeat (len) push_key(pick_key());
    n = len;
    case ($urandom_range(9))
      0, 1, 2: push_key(KEY_LF);
      3, 4, 5: push_key(KEY_CR);
      6, 7, 8: push_key(KEY_CTRL_D);
      default: ;
    endcase
    n++;
    pops = $urandom_range(0, len + 4);
    for (int unsigned i = 0; i < pops; i++) push_read(i == 0 || $urandom_range(9) == 0);
    return n + pops;
  endfunction

  task automatic drain();
    while (pending_q.size() != 0 || in_if.valid || reply_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, bit long_hold);
    int unsigned n;
    n = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (long_hold) hold_go = 1'b1;
    while (n < PHASE_ITEMS) n += queue_session();
    drain();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.opcode <= OP_KEY;
      in_if.key_code <= KEY_NUL;
      in_if.read_first <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        new_res = tty_predict(in_if.opcode, in_if.key_code, in_if.read_first);
        reply_q.push_back(new_res);
        if (in_if.opcode == OP_KEY) begin
          n_keys++;
          if (new_res.line_committed) n_commits++;
          if (new_res.erase_count > max_kill) max_kill = new_res.erase_count;
          if (!new_res.echo_valid && !new_res.dump_request && in_if.key_code != KEY_NUL &&
              in_if.key_code != KEY_CTRL_U && in_if.key_code != KEY_CTRL_H &&
              in_if.key_code != KEY_DEL) n_drops++;
        end else begin
          n_reads++;
          if (new_res.read_status == RS_EOF) n_eof++;
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_item = pending_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.opcode <= nxt_item.opcode;
          in_if.key_code <= nxt_item.key_code;
          in_if.read_first <= nxt_item.read_first;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      got_res.echo_valid = out_if.echo_valid;
      got_res.echo_char = out_if.echo_char;
      got_res.erase_count = out_if.erase_count;
      got_res.dump_request = out_if.dump_request;
      got_res.line_committed = out_if.line_committed;
      got_res.read_status = out_if.read_status;
      got_res.read_char = out_if.read_char;
      if (reply_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("result %0d arrived with nothing outstanding", n_results);
      end else begin
        want_res = reply_q.pop_front();
        if (got_res !== want_res) begin
          n_err++;
          if (n_err <= 10) begin
            $display("result %0d: want echo %b/%h erase %0d dump %b commit %b st %0d char %h",
                     n_results, want_res.echo_valid, want_res.echo_char, want_res.erase_count,
                     want_res.dump_request, want_res.line_committed, want_res.read_status,
                     want_res.read_char);
            $display("result %0d: got  echo %b/%h erase %0d dump %b commit %b st %0d char %h",
                     n_results, got_res.echo_valid, got_res.echo_char, got_res.erase_count,
                     got_res.dump_request, got_res.line_committed, got_res.read_status,
                     got_res.read_char);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (pending_q.size() == 0 && !in_if.valid && reply_q.size() == 0)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("no progress for %0d cycles", stall_cnt);
      $display("console_line_editor_buffer: mismatch");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    push_key(KEY_NUL);
    push_key(KEY_CTRL_P);
    push_key(KEY_CTRL_H);
    push_key(KEY_DEL);
    push_read(1'b1);
    push_key(8'h61);
    push_key(8'hff);
    push_key(8'h80);
    push_key(KEY_DEL);
    push_key(8'h62);
    push_key(KEY_LF);
    push_key(8'h63);
    push_key(8'h64);
    push_key(KEY_CTRL_U);
    push_key(KEY_CTRL_U);
    push_key(KEY_CR);
    push_key(KEY_CTRL_D);
    push_read(1'b1);
    repeat (4) push_read(1'b0);
    push_read(1'b0);
    push_read(1'b1);
    push_read(1'b0);
    push_read(1'b1);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    drain();

    run_phase(0, 0, 1'b1);
    run_phase(73, 0, 1'b0);
    run_phase(0, 73, 1'b0);
    run_phase(24, 24, 1'b0);

    repeat (200) @(posedge clk_i);
    $display("ran %0d key items and %0d read items, %0d results checked", n_keys, n_reads,
             n_results);
    $display("%0d commits, %0d end-of-file pops, %0d keys dropped on a full line, kill up to %0d",
             n_commits, n_eof, n_drops, max_kill);
    if (n_err == 0) begin
      $display("console_line_editor_buffer: match");
    end else begin
      $display("%0d mismatches", n_err);
      $display("console_line_editor_buffer: mismatch");
    end
    $finish;
  end

endmodule
